### sv/motor_adc_trimmed_mean_conditioner_top_macros.svh
// Assertion macros for the trimmed-mean conditioner.
`ifndef MOTOR_ADC_TRIMMED_MEAN_CONDITIONER_TOP_MACROS_SVH
`define MOTOR_ADC_TRIMMED_MEAN_CONDITIONER_TOP_MACROS_SVH

// Checked at every clock edge while out of reset.
`define MACTMC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define MACTMC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

### sv/mactmc_pkg.sv
// Shared types and constants for the trimmed-mean conditioner.
package mactmc_pkg;

    typedef logic [7:0] t_byte;
    typedef logic [1:0] t_chan;
    typedef logic [2:0] t_cfg_idx;

    // Channel codes
    localparam t_chan CH_CURRENT = 2'd0;
    localparam t_chan CH_HANDLE  = 2'd1;
    localparam t_chan CH_VOLTAGE = 2'd2;
    localparam t_chan CH_UNUSED  = 2'd3;

    localparam int unsigned NUM_CH = 3;

    // Configuration register indexes
    localparam t_cfg_idx CFG_CURRENT_OFFSET  = 3'd0;
    localparam t_cfg_idx CFG_AVG_CURRENT_LIM = 3'd1;
    localparam t_cfg_idx CFG_PEAK_CURRENT_LIM = 3'd2;
    localparam t_cfg_idx CFG_CONTINUE_THRESH = 3'd3;
    localparam t_cfg_idx CFG_BLOCKUP_TIME    = 3'd4;
    localparam t_cfg_idx CFG_HANDLE_DEAD     = 3'd5;

    // Mapping constants
    localparam t_byte HANDLE_LOW  = 8'd50;
    localparam t_byte HANDLE_HIGH = 8'd220;
    localparam t_byte HANDLE_FULL = 8'd177;
    localparam t_byte DUTY_BIAS   = 8'd50;
    localparam t_byte BYTE_MAX    = 8'd255;

    // Per-channel accumulator entry
    typedef struct packed {
        logic [3:0]  cnt;
        logic [11:0] sum;
        t_byte       min;
        t_byte       max;
    } t_acc;

    localparam t_acc ACC_RESET = '{cnt: 4'd0, sum: 12'd0, min: BYTE_MAX, max: 8'd0};

endpackage

### sv/motor_adc_trimmed_mean_conditioner_top.sv
// Trimmed-mean ADC conditioner: accumulator memory, mean and current/handle mapping.
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one tagged converter sample per
//   transfer: channel, sample, PWM width, compensation flag, PWM count high byte.
//   Output channel (o_out_valid / i_out_ready) carries one result each time a
//   channel has collected SAMPLES_PER_MEAN samples; other samples give nothing,
//   as do samples tagged with the unused channel code.
//   Config port: i_cfg_we writes i_cfg_data into register i_cfg_idx; indexes
//   above the handle dead offset are ignored. Write only while the block is idle.
// Timing:
//   One sample per cycle sustained while no result is held on the output. A result
//   passes stage 1, stage 2, stage 3 and the output register after the transfer of
//   the sample that completes it. The per-channel accumulators live in a 3-entry
//   memory with a registered read; a read-modify-write follows each sample and a
//   forwarding register covers back-to-back samples of the same channel.
// Reset and stall:
//   Synchronous reset clears the config registers to their defaults, the entry
//   valid bits (an invalid entry reads as an empty accumulator) and all stage
//   valids. While a result waits on a low i_out_ready the whole pipeline holds
//   and o_in_ready drops; it rises again the cycle the result is taken.
module motor_adc_trimmed_mean_conditioner_top #(
    parameter int SAMPLES_PER_MEAN = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_we,
    input  mactmc_pkg::t_cfg_idx  i_cfg_idx,
    input  mactmc_pkg::t_byte     i_cfg_data,
    // sample channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  mactmc_pkg::t_chan     i_channel,
    input  mactmc_pkg::t_byte     i_sample,
    input  mactmc_pkg::t_byte     i_pwm_width,
    input  logic                  i_compensating,
    input  mactmc_pkg::t_byte     i_pwm_count_high,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output mactmc_pkg::t_chan     o_result_channel,
    output mactmc_pkg::t_byte     o_mean_value,
    output mactmc_pkg::t_byte     o_conditioned_value,
    output mactmc_pkg::t_byte     o_peak_current,
    output logic                  o_limit_flag,
    output logic                  o_refresh_request,
    output logic                  o_blockup_request,
    output logic                  o_continuous_flag
);
    import mactmc_pkg::*;

    `include "motor_adc_trimmed_mean_conditioner_top_macros.svh"

    localparam logic [3:0] LP_NSAMP = 4'(SAMPLES_PER_MEAN);

    // config registers
    t_byte r_offset, r_avg_lim, r_peak_lim, r_cont_thr, r_blk_time, r_dead;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset   <= 8'd0;
            r_avg_lim  <= BYTE_MAX;
            r_peak_lim <= BYTE_MAX;
            r_cont_thr <= BYTE_MAX;
            r_blk_time <= BYTE_MAX;
            r_dead     <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CURRENT_OFFSET:   r_offset   <= i_cfg_data;
                CFG_AVG_CURRENT_LIM:  r_avg_lim  <= i_cfg_data;
                CFG_PEAK_CURRENT_LIM: r_peak_lim <= i_cfg_data;
                CFG_CONTINUE_THRESH:  r_cont_thr <= i_cfg_data;
                CFG_BLOCKUP_TIME:     r_blk_time <= i_cfg_data;
                CFG_HANDLE_DEAD:      r_dead     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advance: everything moves unless a result is held
    logic r_out_valid;
    logic adv;
    logic accept;

    assign adv        = !r_out_valid || i_out_ready;
    assign o_in_ready = adv;
    assign accept     = i_in_valid && adv;

    // accumulator memory and entry valid bits
    t_acc r_mem [NUM_CH];
    logic [NUM_CH-1:0] r_mem_vld;

    // stage 1 registers (read-modify-write stage)
    logic  r_s1_valid;
    t_chan r_s1_ch;
    t_byte r_s1_sample, r_s1_pwm, r_s1_cnt_hi;
    logic  r_s1_comp;
    t_acc  r_rd_data, r_fwd_data;
    logic  r_rd_vld, r_fwd_hit;

    t_acc        cur, wdata;
    logic        s1_act, s1_done;
    logic [3:0]  n_cnt;
    logic [11:0] n_sum, trimmed;
    t_byte       n_min, n_max, s1_mean;

    // current accumulator: forwarded write, memory word, or empty entry
    always_comb begin
        if (r_fwd_hit) begin
            cur = r_fwd_data;
        end else if (r_rd_vld) begin
            cur = r_rd_data;
        end else begin
            cur = ACC_RESET;
        end
        s1_act  = r_s1_valid && (r_s1_ch != CH_UNUSED);
        n_sum   = cur.sum + {4'd0, r_s1_sample};
        n_min   = (r_s1_sample < cur.min) ? r_s1_sample : cur.min;
        n_max   = (r_s1_sample > cur.max) ? r_s1_sample : cur.max;
        n_cnt   = cur.cnt + 4'd1;
        s1_done = (n_cnt >= LP_NSAMP);
        trimmed = n_sum - {4'd0, n_min} - {4'd0, n_max};
        s1_mean = trimmed[10:3];
        wdata   = s1_done ? ACC_RESET
                          : t_acc'{cnt: n_cnt, sum: n_sum, min: n_min, max: n_max};
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (adv && s1_act) begin
            r_mem[r_s1_ch] <= wdata;
        end
        if (adv && (i_channel != CH_UNUSED)) begin
            r_rd_data <= r_mem[i_channel];
        end
    end

    // control of stage 1, valid bits and forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem_vld  <= '0;
            r_s1_valid <= 1'b0;
            r_fwd_hit  <= 1'b0;
            r_rd_vld   <= 1'b0;
        end else if (adv) begin
            if (s1_act) begin
                r_mem_vld[r_s1_ch] <= 1'b1;
            end
            r_s1_valid <= accept;
            r_fwd_hit  <= accept && s1_act && (r_s1_ch == i_channel);
            r_rd_vld   <= (i_channel != CH_UNUSED) && r_mem_vld[i_channel]
                          && !(s1_act && (r_s1_ch == i_channel));
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_fwd_data  <= wdata;
            r_s1_ch     <= i_channel;
            r_s1_sample <= i_sample;
            r_s1_pwm    <= i_pwm_width;
            r_s1_comp   <= i_compensating;
            r_s1_cnt_hi <= i_pwm_count_high;
        end
    end

    // stage 2: completed mean
    logic  r_s2_valid;
    t_chan r_s2_ch;
    t_byte r_s2_mean, r_s2_pwm, r_s2_cnt_hi;
    logic  r_s2_comp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (adv) begin
            r_s2_valid <= s1_act && s1_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_ch     <= r_s1_ch;
            r_s2_mean   <= s1_mean;
            r_s2_pwm    <= r_s1_pwm;
            r_s2_comp   <= r_s1_comp;
            r_s2_cnt_hi <= r_s1_cnt_hi;
        end
    end

    // stage 3: peak current, duty product, handle map
    logic        r_s3_valid;
    t_chan       r_s3_ch;
    t_byte       r_s3_mean, r_s3_pp, r_s3_cond, r_s3_cnt_hi;
    logic        r_s3_comp;
    logic [16:0] r_s3_prod;

    t_byte       s2_pp, s2_cond, handle_val, handle_diff;
    logic [8:0]  factor, handle_lo;

    always_comb begin
        s2_pp  = (r_s2_mean > r_offset) ? (r_s2_mean - r_offset) : 8'd0;
        factor = {1'b0, r_s2_pwm} - {4'd0, r_s2_pwm[7:3]} + {1'b0, DUTY_BIAS};
        // throttle: dead band below, cutoff above, full scale near the top
        handle_lo   = {1'b0, HANDLE_LOW} + {1'b0, r_dead};
        handle_diff = r_s2_mean - HANDLE_LOW;
        if (({1'b0, r_s2_mean} < handle_lo) || (r_s2_mean > HANDLE_HIGH)) begin
            handle_val = 8'd0;
        end else if (r_s2_mean > HANDLE_FULL) begin
            handle_val = BYTE_MAX;
        end else begin
            handle_val = {handle_diff[6:0], 1'b0};
        end
        s2_cond = (r_s2_ch == CH_HANDLE) ? handle_val : r_s2_mean;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else if (adv) begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_ch     <= r_s2_ch;
            r_s3_mean   <= r_s2_mean;
            r_s3_pp     <= s2_pp;
            r_s3_cond   <= s2_cond;
            r_s3_comp   <= r_s2_comp;
            r_s3_cnt_hi <= r_s2_cnt_hi;
            r_s3_prod   <= {9'd0, s2_pp} * {8'd0, factor};
        end
    end

    // output stage: saturate product, current flags
    t_byte weighted, n_cond, n_pp;
    logic  n_lim, n_refr, n_blk, n_cont, is_cur;

    always_comb begin
        is_cur   = (r_s3_ch == CH_CURRENT);
        weighted = r_s3_prod[16] ? BYTE_MAX : r_s3_prod[15:8];
        n_lim    = is_cur && ((weighted > r_avg_lim) || (r_s3_pp > r_peak_lim));
        n_refr   = n_lim && !r_s3_comp;
        n_blk    = n_lim && (r_s3_cnt_hi > r_blk_time);
        n_cont   = is_cur && (weighted > r_cont_thr);
        n_cond   = is_cur ? weighted : r_s3_cond;
        n_pp     = is_cur ? r_s3_pp : 8'd0;
    end

    t_chan r_out_ch;
    t_byte r_out_mean, r_out_cond, r_out_pp;
    logic  r_out_lim, r_out_refr, r_out_blk, r_out_cont;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_ch   <= r_s3_ch;
            r_out_mean <= r_s3_mean;
            r_out_cond <= n_cond;
            r_out_pp   <= n_pp;
            r_out_lim  <= n_lim;
            r_out_refr <= n_refr;
            r_out_blk  <= n_blk;
            r_out_cont <= n_cont;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_result_channel    = r_out_ch;
    assign o_mean_value        = r_out_mean;
    assign o_conditioned_value = r_out_cond;
    assign o_peak_current      = r_out_pp;
    assign o_limit_flag        = r_out_lim;
    assign o_refresh_request   = r_out_refr;
    assign o_blockup_request   = r_out_blk;
    assign o_continuous_flag   = r_out_cont;

    // checks
    `MACTMC_ASSERT(a_stall_only_when_held, !o_in_ready |-> r_out_valid, "input stalled with empty output")
    `MACTMC_ASSERT(a_no_unused_result, r_out_valid |-> (r_out_ch != CH_UNUSED), "result for unused channel")
    `MACTMC_ASSERT(a_flags_current_only, (r_out_valid && (r_out_ch != CH_CURRENT)) |-> (!r_out_lim && !r_out_cont && (r_out_pp == 8'd0)), "current flags on other channel")
    `MACTMC_ASSERT(a_req_needs_limit, (r_out_refr || r_out_blk) |-> r_out_lim, "request without limit")
    `MACTMC_ASSERT_ALWAYS(a_fwd_has_stage, r_fwd_hit |-> r_s1_valid, "forward hit without sample in stage 1")

endmodule
